FILE: hw/rtl/tgc_pkg.sv
// Shared types and constants for the text grid cursor engine.
`default_nettype none
package tgc_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int TAB_STOP = 8;
    localparam int ADDR_W   = 13;
    localparam int CNT_W    = 14;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS    = 7'd25;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_PUSH  = 3'd2;
    localparam logic [2:0] OP_POP   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    typedef enum logic [3:0] {
        K_NL, K_CR, K_BS, K_TAB, K_CHAR, K_CLEAR, K_PUSH, K_POP, K_READ, K_NOP
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic [5:0] rr;
        logic [6:0] rc;
    } cmd_t;

    // Row times width, wide enough for the full grid size.
    function automatic logic [CNT_W-1:0] mul_rc(logic [6:0] a, logic [7:0] b);
        logic [14:0] p;
        p = {8'd0, a} * {7'd0, b};
        return p[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tgc_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface tgc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] char_in;
    logic [5:0] read_row;
    logic [6:0] read_col;
    modport source (output valid, op, char_in, read_row, read_col, input ready);
    modport sink   (input valid, op, char_in, read_row, read_col, output ready);
endinterface

interface tgc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_value;
    logic [7:0] cursor_col;
    logic [5:0] cursor_row;
    logic       failed;
    modport source (output valid, cell_value, cursor_col, cursor_row, failed, input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, failed, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tgc_front.sv
// Front end: accepts command words, classifies them and queues them.
`default_nettype none
module tgc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tgc_in_if.sink             cmd_in,
    input  wire logic          hold,
    output tgc_pkg::cmd_t      q_cmd,
    output logic               q_valid,
    input  wire logic          q_pop
);

    tgc_pkg::cmd_t cmd_d;
    tgc_pkg::cmd_t fifo_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    count_reg;
    logic          push;

    // Classify the incoming word.
    always_comb
    begin
        cmd_d.ch = cmd_in.char_in;
        cmd_d.rr = cmd_in.read_row;
        cmd_d.rc = cmd_in.read_col;
        case (cmd_in.op)
            tgc_pkg::OP_PUT:
            begin
                case (cmd_in.char_in)
                    tgc_pkg::CH_NL:  cmd_d.kind = tgc_pkg::K_NL;
                    tgc_pkg::CH_CR:  cmd_d.kind = tgc_pkg::K_CR;
                    tgc_pkg::CH_BS:  cmd_d.kind = tgc_pkg::K_BS;
                    tgc_pkg::CH_TAB: cmd_d.kind = tgc_pkg::K_TAB;
                    default:         cmd_d.kind = tgc_pkg::K_CHAR;
                endcase
            end
            tgc_pkg::OP_CLEAR: cmd_d.kind = tgc_pkg::K_CLEAR;
            tgc_pkg::OP_PUSH:  cmd_d.kind = tgc_pkg::K_PUSH;
            tgc_pkg::OP_POP:   cmd_d.kind = tgc_pkg::K_POP;
            tgc_pkg::OP_READ:  cmd_d.kind = tgc_pkg::K_READ;
            default:           cmd_d.kind = tgc_pkg::K_NOP;
        endcase
    end

    assign cmd_in.ready = (count_reg != 2'd2) && !hold;
    assign push         = cmd_in.valid && cmd_in.ready;
    assign q_valid      = (count_reg != 2'd0);
    assign q_cmd        = fifo_reg[rptr_reg];

    // Two-entry command queue.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= cmd_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tgc_engine.sv
// Back end: grid and save memories, cursor, sequencer and result register.
`default_nettype none
module tgc_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tgc_pkg::cmd_t q_cmd,
    input  wire logic          q_valid,
    output logic               q_pop,
    output logic               init_busy,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [7:0]    cfg_wdata,
    tgc_out_if.source          res_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_PUT, S_PLAIN, S_NL, S_COPY, S_BLANK, S_SWEEP,
        S_RDA, S_RDD, S_DONE
    } state_t;

    typedef enum logic [1:0] {M_SCROLL, M_PUSH, M_POP} mode_t;

    localparam int AW = tgc_pkg::ADDR_W;
    localparam int CW = tgc_pkg::CNT_W;

    state_t                state_reg;
    mode_t                 mode_reg;
    tgc_pkg::cmd_t         cmd_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         end_reg;
    logic [7:0]            col_reg;
    logic [5:0]            row_reg;
    logic [7:0]            s_col_reg;
    logic [5:0]            s_row_reg;
    logic                  s_valid_reg;
    logic [7:0]            cols_reg;
    logic [6:0]            rows_reg;
    logic                  cp_pend_reg;
    logic [AW-1:0]         cp_addr_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic                  sweep_res_reg;
    logic [7:0]            value_reg;
    logic                  failed_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_value_reg;
    logic [7:0]            out_col_reg;
    logic [5:0]            out_row_reg;
    logic                  out_failed_reg;

    logic [7:0]            cell_mem [tgc_pkg::DEPTH];
    logic [7:0]            saved_mem [tgc_pkg::DEPTH];
    logic [7:0]            cell_rdata_reg;
    logic [7:0]            saved_rdata_reg;

    logic                  cell_we;
    logic [AW-1:0]         cell_wa;
    logic [7:0]            cell_wd;
    logic [AW-1:0]         cell_ra;
    logic                  saved_we;
    logic [7:0]            saved_wd;
    logic [AW-1:0]         saved_ra;

    logic [7:0]            nc;
    logic [6:0]            nr;
    logic [CW-1:0]         row_base;
    logic [CW-1:0]         cur_addr;
    logic [CW-1:0]         rd_addr;
    logic [CW-1:0]         src_addr;
    logic [7:0]            ncol;
    logic                  tab_stop;
    logic                  plain_kind;
    logic                  out_free;

    // Effective geometry with out-of-range register values folded in.
    always_comb
    begin
        if (cols_reg == 8'd0)
            nc = 8'd1;
        else if (cols_reg > 8'(tgc_pkg::MAX_COLS))
            nc = 8'(tgc_pkg::MAX_COLS);
        else
            nc = cols_reg;
        if (rows_reg == 7'd0)
            nr = 7'd1;
        else if (rows_reg > 7'(tgc_pkg::MAX_ROWS))
            nr = 7'(tgc_pkg::MAX_ROWS);
        else
            nr = rows_reg;
    end

    assign row_base   = tgc_pkg::mul_rc({1'b0, row_reg}, nc);
    assign cur_addr   = row_base + {6'd0, col_reg};
    assign rd_addr    = tgc_pkg::mul_rc({1'b0, cmd_reg.rr}, nc) + {7'd0, cmd_reg.rc};
    assign src_addr   = cnt_reg + ((mode_reg == M_SCROLL) ? {6'd0, nc} : {CW{1'b0}});
    assign ncol       = col_reg + 8'd1;
    assign tab_stop   = ((nc < 8'(tgc_pkg::TAB_STOP)) && (ncol >= nc))
                        || ((ncol % 8'(tgc_pkg::TAB_STOP)) == 8'd0);
    assign plain_kind = (cmd_reg.kind == tgc_pkg::K_CHAR) || (cmd_reg.kind == tgc_pkg::K_TAB);
    assign out_free   = !out_valid_reg || res_out.ready;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign init_busy  = (state_reg == S_SWEEP) && !sweep_res_reg;

    // Memory port selection.
    always_comb
    begin
        cell_we  = 1'b0;
        cell_wa  = cp_addr_reg;
        cell_wd  = 8'd0;
        cell_ra  = src_addr[AW-1:0];
        saved_we = 1'b0;
        saved_wd = cell_rdata_reg;
        saved_ra = src_addr[AW-1:0];
        if (cp_pend_reg)
        begin
            case (mode_reg)
                M_SCROLL:
                begin
                    cell_we = 1'b1;
                    cell_wd = cell_rdata_reg;
                end
                M_POP:
                begin
                    cell_we = 1'b1;
                    cell_wd = saved_rdata_reg;
                end
                default: saved_we = 1'b1;
            endcase
        end
        case (state_reg)
            S_PUT:
            begin
                if ((cmd_reg.kind == tgc_pkg::K_BS) && (col_reg != 8'd0))
                begin
                    cell_we = 1'b1;
                    cell_wa = 13'(cur_addr - 14'd1);
                end
            end
            S_PLAIN:
            begin
                if (col_reg < nc)
                begin
                    cell_we = 1'b1;
                    cell_wa = cur_addr[AW-1:0];
                    cell_wd = (cmd_reg.kind == tgc_pkg::K_TAB) ? tgc_pkg::CH_SPACE : cmd_reg.ch;
                end
            end
            S_BLANK, S_SWEEP:
            begin
                cell_we = 1'b1;
                cell_wa = cnt_reg[AW-1:0];
            end
            S_RDA:   cell_ra = rd_addr_reg;
            default: ;
        endcase
    end

    // Grid and save memories, one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_wa] <= cell_wd;
        end
        cell_rdata_reg <= cell_mem[cell_ra];
        if (saved_we)
        begin
            saved_mem[cp_addr_reg] <= saved_wd;
        end
        saved_rdata_reg <= saved_mem[saved_ra];
    end

    // Sequencer, cursor and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            mode_reg       <= M_SCROLL;
            cmd_reg        <= tgc_pkg::cmd_t'('0);
            cnt_reg        <= '0;
            end_reg        <= '0;
            col_reg        <= 8'd0;
            row_reg        <= 6'd0;
            s_col_reg      <= 8'd0;
            s_row_reg      <= 6'd0;
            s_valid_reg    <= 1'b0;
            cols_reg       <= tgc_pkg::RST_COLUMNS;
            rows_reg       <= tgc_pkg::RST_ROWS;
            cp_pend_reg    <= 1'b0;
            cp_addr_reg    <= '0;
            rd_addr_reg    <= '0;
            sweep_res_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= 8'd0;
            out_col_reg    <= 8'd0;
            out_row_reg    <= 6'd0;
            out_failed_reg <= 1'b0;
            value_reg      <= 8'd0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res_out.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    value_reg  <= 8'd0;
                    failed_reg <= 1'b0;
                    cnt_reg    <= '0;
                    end_reg    <= tgc_pkg::mul_rc(nr, nc);
                    case (cmd_reg.kind)
                        tgc_pkg::K_NL, tgc_pkg::K_CR, tgc_pkg::K_BS,
                        tgc_pkg::K_TAB, tgc_pkg::K_CHAR:
                        begin
                            // A stale cursor is pulled back inside the grid.
                            if ({1'b0, row_reg} >= nr)
                                row_reg <= 6'(nr - 7'd1);
                            if (col_reg > nc)
                                col_reg <= nc;
                            state_reg <= S_PUT;
                        end
                        tgc_pkg::K_CLEAR:
                        begin
                            sweep_res_reg <= 1'b1;
                            state_reg     <= S_SWEEP;
                        end
                        tgc_pkg::K_PUSH:
                        begin
                            mode_reg  <= M_PUSH;
                            state_reg <= S_COPY;
                        end
                        tgc_pkg::K_POP:
                        begin
                            if (!s_valid_reg)
                            begin
                                failed_reg <= 1'b1;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                mode_reg  <= M_POP;
                                state_reg <= S_COPY;
                            end
                        end
                        tgc_pkg::K_READ:
                        begin
                            if (({1'b0, cmd_reg.rr} < nr) && ({1'b0, cmd_reg.rc} < nc))
                            begin
                                rd_addr_reg <= rd_addr[AW-1:0];
                                state_reg   <= S_RDA;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_PUT:
                begin
                    case (cmd_reg.kind)
                        tgc_pkg::K_NL: state_reg <= S_NL;
                        tgc_pkg::K_CR:
                        begin
                            col_reg   <= 8'd0;
                            state_reg <= S_DONE;
                        end
                        tgc_pkg::K_BS:
                        begin
                            if (col_reg != 8'd0)
                                col_reg <= col_reg - 8'd1;
                            state_reg <= S_DONE;
                        end
                        default: state_reg <= S_PLAIN;
                    endcase
                end
                S_PLAIN:
                begin
                    // Wrap first, else store the byte and advance.
                    if (col_reg >= nc)
                        state_reg <= S_NL;
                    else
                    begin
                        col_reg <= ncol;
                        if ((cmd_reg.kind != tgc_pkg::K_TAB) || tab_stop)
                            state_reg <= S_DONE;
                    end
                end
                S_NL:
                begin
                    col_reg <= 8'd0;
                    if (({1'b0, row_reg} + 7'd1) >= nr)
                    begin
                        row_reg   <= 6'(nr - 7'd1);
                        cnt_reg   <= '0;
                        end_reg   <= tgc_pkg::mul_rc(nr - 7'd1, nc);
                        mode_reg  <= M_SCROLL;
                        state_reg <= S_COPY;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 6'd1;
                        state_reg <= plain_kind ? S_PLAIN : S_DONE;
                    end
                end
                S_COPY:
                begin
                    // Read one entry a cycle; its write follows in the next cycle.
                    if (cnt_reg < end_reg)
                    begin
                        cp_pend_reg <= 1'b1;
                        cp_addr_reg <= cnt_reg[AW-1:0];
                        cnt_reg     <= cnt_reg + 14'd1;
                    end
                    else
                    begin
                        cp_pend_reg <= 1'b0;
                        if (!cp_pend_reg)
                        begin
                            case (mode_reg)
                                M_SCROLL:
                                begin
                                    end_reg   <= end_reg + {6'd0, nc};
                                    state_reg <= S_BLANK;
                                end
                                M_PUSH:
                                begin
                                    s_col_reg     <= col_reg;
                                    s_row_reg     <= row_reg;
                                    s_valid_reg   <= 1'b1;
                                    cnt_reg       <= '0;
                                    sweep_res_reg <= 1'b1;
                                    state_reg     <= S_SWEEP;
                                end
                                default:
                                begin
                                    col_reg     <= s_col_reg;
                                    row_reg     <= s_row_reg;
                                    s_valid_reg <= 1'b0;
                                    state_reg   <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_BLANK:
                begin
                    cnt_reg <= cnt_reg + 14'd1;
                    if ((cnt_reg + 14'd1) == end_reg)
                        state_reg <= plain_kind ? S_PLAIN : S_DONE;
                end
                S_SWEEP:
                begin
                    cnt_reg <= cnt_reg + 14'd1;
                    if (cnt_reg[AW-1:0] == {AW{1'b1}})
                    begin
                        col_reg   <= 8'd0;
                        row_reg   <= 6'd0;
                        state_reg <= sweep_res_reg ? S_DONE : S_IDLE;
                    end
                end
                S_RDA: state_reg <= S_RDD;
                S_RDD:
                begin
                    value_reg <= cell_rdata_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= value_reg;
                        out_col_reg    <= col_reg;
                        out_row_reg    <= row_reg;
                        out_failed_reg <= failed_reg;
                        sweep_res_reg  <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // Register writes drop any saved screen.
            if (cfg_we)
            begin
                s_valid_reg <= 1'b0;
                if (cfg_index == tgc_pkg::CFG_COLUMNS)
                    cols_reg <= cfg_wdata;
                else
                    rows_reg <= cfg_wdata[6:0];
            end
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.cell_value = out_value_reg;
    assign res_out.cursor_col = out_col_reg;
    assign res_out.cursor_row = out_row_reg;
    assign res_out.failed     = out_failed_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/text_grid_cursor_engine_top.sv
// Top level of the text grid cursor engine.
//
//   channel    dir   handshake       payload
//   cmd_in     in    valid/ready     op, char_in, read_row, read_col
//   res_out    out   valid/ready     cell_value, cursor_col, cursor_row, failed
//   cfg        in    cfg_we          cfg_index, cfg_wdata
//
// Each word gives one result. A scroll copies (rows-1)*columns cells and blanks one row,
// a clear sweeps all 8192 cells, push copies rows*columns cells then sweeps, pop copies
// rows*columns cells. After reset a clearing pass over all 8192 cells runs before the
// first word is taken. A two-word queue keeps taking words, until it is full, while the
// back end works or the result register waits on res_out.ready.
`default_nettype none
module text_grid_cursor_engine_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tgc_in_if.sink          cmd_in,
    tgc_out_if.source       res_out,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    tgc_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_pop;
    logic          init_busy;

    tgc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_in),
        .hold    (init_busy),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    tgc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (q_cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_out   (res_out)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/tgc_checker.sv
// Port-level checks for the text grid cursor engine, bound to the top level.
`default_nettype none
module tgc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] cell_value,
    input wire logic [7:0] cursor_col,
    input wire logic       failed
);

    logic [2:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Words taken but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else
            pend_reg <= pend_reg + {2'd0, in_acc} - {2'd0, out_acc};
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_value) && $stable(failed))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failed |-> cell_value == 8'd0)
        else $error("failed pop carries a cell value");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_col <= 8'd128)
        else $error("cursor column beyond the widest grid");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result without a pending word");

endmodule

bind text_grid_cursor_engine_top tgc_checker u_tgc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmd_in.valid),
    .in_ready   (cmd_in.ready),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .cell_value (res_out.cell_value),
    .cursor_col (res_out.cursor_col),
    .failed     (res_out.failed)
);
`default_nettype wire
